// ----- rtl/core/icl_pkg.sv -----
package icl_pkg;

  // Table geometry and sample format
  localparam int TABLE_BINS       = 1024;
  localparam int SAMPLE_FRAC_BITS = 16;
  localparam int TABLE_DEPTH      = TABLE_BINS + 2;
  localparam int ADDR_W           = $clog2(TABLE_DEPTH);

  // Field widths
  localparam int CMD_W       = 1;
  localparam int INDEX_W     = 11;
  localparam int VALUE_W     = 24;
  localparam int SAMPLE_W    = 20;
  localparam int IN_FIELDS_W = INDEX_W + VALUE_W + SAMPLE_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = VALUE_W;

  // Result queue behind the datapath
  localparam int FIFO_DEPTH = 4;

  // Wide accumulator for the final add before saturation
  localparam int SUM_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  function automatic logic [VALUE_W-1:0] sat_value(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    logic [VALUE_W-1:0]      res;
    hi  = SUM_W'(signed'({1'b0, {(VALUE_W-1){1'b1}}}));
    lo  = SUM_W'(signed'({1'b1, {(VALUE_W-1){1'b0}}}));
    res = v[VALUE_W-1:0];
    if (v > hi) begin
      res = {1'b0, {(VALUE_W-1){1'b1}}};
    end else if (v < lo) begin
      res = {1'b1, {(VALUE_W-1){1'b0}}};
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/interpolated_curve_lookup_unit.sv -----
// A lookup transaction's result goes through the table read, the multiply, then
// round/add/saturate into the result queue. Throughput: one transaction per cycle
// unless the input stalls; the dual-read table returns both bin entries at once.
// Input stalls while 4 lookups are outstanding, which happens only when the output side holds off.
// Reset clears the negative-side slope to 0 and empties the pipeline; table contents stay
// undefined until written, with no clearing pass.
module interpolated_curve_lookup_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [10:0] entry_index, [34:11] entry_value, [54:35] sample, [55] unused
  input  logic [icl_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [0] cmd
  input  logic [icl_pkg::CMD_W-1:0]          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [23:0] mapped_value
  output logic [icl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [icl_pkg::VALUE_W-1:0]        cfg_data_i
);

  localparam int F        = icl_pkg::SAMPLE_FRAC_BITS;
  localparam int VALUE_W  = icl_pkg::VALUE_W;
  localparam int SAMPLE_W = icl_pkg::SAMPLE_W;
  localparam int INDEX_W  = icl_pkg::INDEX_W;
  localparam int ADDR_W   = icl_pkg::ADDR_W;
  localparam int SUM_W    = icl_pkg::SUM_W;
  localparam int LIM      = 4 << F;
  localparam int SC_W     = F + 3;
  localparam int BIN_W    = $clog2(icl_pkg::TABLE_BINS + 1);
  localparam int POS_W    = SC_W + BIN_W;
  localparam int FRAC_W   = F + 2;
  localparam int DIFF_W   = VALUE_W + 1;
  localparam int PROD_W   = DIFF_W + FRAC_W + 1;
  localparam int TOE_W    = SAMPLE_W + VALUE_W;
  localparam int TSH_W    = TOE_W - F;
  localparam int CSH_W    = PROD_W - FRAC_W;
  localparam int CRED_W   = $clog2(icl_pkg::FIFO_DEPTH + 1);
  localparam int PTR_W    = $clog2(icl_pkg::FIFO_DEPTH);
  localparam longint TOE_HALF = 64'sd1 <<< (F - 1);
  localparam longint CUR_HALF = 64'sd1 <<< (F + 1);

  // Input fields
  icl_pkg::cmd_e               cmd;
  logic [INDEX_W-1:0]          entry_index;
  logic [VALUE_W-1:0]          entry_value;
  logic signed [SAMPLE_W-1:0]  sample;

  assign cmd         = icl_pkg::cmd_e'(s_axis_tuser);
  assign entry_index = s_axis_tdata[INDEX_W-1:0];
  assign entry_value = s_axis_tdata[INDEX_W +: VALUE_W];
  assign sample      = signed'(s_axis_tdata[INDEX_W+VALUE_W +: SAMPLE_W]);

  logic s_acc, wr_en, lk_en, pop;
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign lk_en = s_acc && (cmd == icl_pkg::CMD_LOOKUP);
  assign wr_en = s_acc && (cmd == icl_pkg::CMD_WRITE)
                 && (32'(entry_index) < 32'(icl_pkg::TABLE_DEPTH));
  assign pop   = m_axis_tvalid && m_axis_tready;

  // Configuration register
  logic signed [VALUE_W-1:0] neg_slope_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_slope_q <= '0;
    end else if (cfg_valid_i) begin
      neg_slope_q <= signed'(cfg_data_i);
    end
  end

  // Address generation: clamp at 4.0, scale by the bin count, split bin and fraction
  logic [31:0]             idx_ext;
  logic [ADDR_W-1:0]       wr_addr;
  logic signed [31:0]      smp_ext;
  logic [SC_W-1:0]         s_cl;
  logic [POS_W-1:0]        pos;
  logic [BIN_W:0]          bin_raw;
  logic [31:0]             bin_ext, bin1_ext;
  logic [ADDR_W-1:0]       rd_addr0, rd_addr1;
  logic [FRAC_W-1:0]       frac;
  logic signed [TOE_W-1:0] toe_p;

  always_comb begin
    idx_ext  = 32'(entry_index);
    wr_addr  = idx_ext[ADDR_W-1:0];
    smp_ext  = 32'(sample);
    if (smp_ext > 32'(LIM)) begin
      s_cl = SC_W'(LIM);
    end else begin
      s_cl = smp_ext[SC_W-1:0];
    end
    pos     = POS_W'(s_cl) * POS_W'(icl_pkg::TABLE_BINS);
    bin_raw = pos[POS_W-1:FRAC_W];
    frac    = pos[FRAC_W-1:0];
    bin_ext = 32'(bin_raw);
    if (bin_ext > 32'(icl_pkg::TABLE_BINS)) begin
      bin_ext = 32'(icl_pkg::TABLE_BINS);
    end
    // negative samples need only entry 0
    if (sample[SAMPLE_W-1]) begin
      bin_ext = '0;
    end
    bin1_ext = bin_ext + 32'd1;
    rd_addr0 = bin_ext[ADDR_W-1:0];
    rd_addr1 = bin1_ext[ADDR_W-1:0];
    toe_p    = TOE_W'(sample) * TOE_W'(neg_slope_q);
  end

  // Curve table: one write port, two registered read ports
  logic [VALUE_W-1:0] curve_mem [icl_pkg::TABLE_DEPTH];
  logic [VALUE_W-1:0] e0_q, e1_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      curve_mem[wr_addr] <= entry_value;
    end
    if (lk_en) begin
      e0_q <= curve_mem[rd_addr0];
      e1_q <= curve_mem[rd_addr1];
    end
  end

  // Stage 1 registers
  logic                    v1_q;
  logic                    neg1_q;
  logic [FRAC_W-1:0]       frac1_q;
  logic signed [TOE_W-1:0] toe1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= lk_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lk_en) begin
      neg1_q  <= sample[SAMPLE_W-1];
      frac1_q <= frac;
      toe1_q  <= toe_p;
    end
  end

  // Stage 2: slope times fraction, toe rounding
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [TOE_W-1:0]  toe_rnd;
  logic signed [TSH_W-1:0]  toe_sh;

  always_comb begin
    diff    = DIFF_W'(signed'(e1_q)) - DIFF_W'(signed'(e0_q));
    prod    = PROD_W'(diff) * PROD_W'(signed'({1'b0, frac1_q}));
    toe_rnd = toe1_q + TOE_W'(TOE_HALF);
    toe_sh  = signed'(toe_rnd[TOE_W-1:F]);
  end

  logic                     v2_q;
  logic                     neg2_q;
  logic signed [PROD_W-1:0] prod2_q;
  logic signed [TSH_W-1:0]  toe2_q;
  logic signed [VALUE_W-1:0] e0_2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      neg2_q  <= neg1_q;
      prod2_q <= prod;
      toe2_q  <= toe_sh;
      e0_2_q  <= signed'(e0_q);
    end
  end

  // Stage 3: round the blend, add the base entry, saturate
  logic signed [PROD_W-1:0] cur_rnd;
  logic signed [CSH_W-1:0]  cur_sh;
  logic signed [SUM_W-1:0]  cur_sum, toe_sum;
  logic [VALUE_W-1:0]       result;

  always_comb begin
    cur_rnd = prod2_q + PROD_W'(CUR_HALF);
    cur_sh  = signed'(cur_rnd[PROD_W-1:FRAC_W]);
    cur_sum = SUM_W'(cur_sh) + SUM_W'(e0_2_q);
    toe_sum = SUM_W'(toe2_q) + SUM_W'(e0_2_q);
    result  = icl_pkg::sat_value(neg2_q ? toe_sum : cur_sum);
  end

  // Result queue; credits reserve a slot for every lookup in flight
  logic [VALUE_W-1:0] fifo_q [icl_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CRED_W-1:0]  fifo_cnt_q, fifo_cnt_d;
  logic [CRED_W-1:0]  credit_q, credit_d;

  always_comb begin
    fifo_cnt_d = fifo_cnt_q + CRED_W'(v2_q) - CRED_W'(pop);
    credit_d   = credit_q + CRED_W'(lk_en) - CRED_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      credit_q   <= '0;
    end else begin
      fifo_cnt_q <= fifo_cnt_d;
      credit_q   <= credit_d;
      if (v2_q) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      fifo_q[wr_ptr_q] <= result;
    end
  end

  assign s_axis_tready = credit_q < CRED_W'(icl_pkg::FIFO_DEPTH);
  assign m_axis_tvalid = fifo_cnt_q != '0;
  assign m_axis_tdata  = fifo_q[rd_ptr_q];

`ifndef SYNTH
  a_credit_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q == fifo_cnt_q + CRED_W'(v1_q) + CRED_W'(v2_q))
    else $error("credit count out of step with pipeline and queue");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= CRED_W'(icl_pkg::FIFO_DEPTH))
    else $error("more lookups outstanding than queue slots");

  a_lookup_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lk_en |=> v1_q)
    else $error("accepted lookup did not enter the pipeline");

  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid || v1_q || v2_q))
    else $error("input stalled with nothing outstanding");
`endif

endmodule
